FILE: rtl/core/nccsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nccsb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int COEF_N     = 24;
    localparam int COEF_IDX_W = 5;
    localparam int DIM_W      = 12;
    localparam int ZN_W       = 31;
    localparam int RECT_W     = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 50;
    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 33;
    localparam int DIV_QW     = 33;
    localparam int DIV_CNT_W  = $clog2(DIV_QW + 1);
    localparam int BND_W      = 34;
    localparam int CMP_W      = (DIM_W + FRAC_BITS + 1 > BND_W) ? DIM_W + FRAC_BITS + 1 : BND_W;
    localparam int PAD        = ((1 << FRAC_BITS) + 50) / 100;
    localparam int T_SHIFT    = 31;

    localparam logic [ZN_W-1:0]  Z_NEAR_RESET = ZN_W'(6554);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(WORD_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(WORD_MIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Z_NEAR      = 2'd0,
        CFG_VIEW_WIDTH  = 2'd1,
        CFG_VIEW_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        K_COEF,
        K_IGNORE,
        K_VERTEX
    } kind_t;

    typedef enum logic [4:0] {
        S_FETCH,
        S_MUL,
        S_ACC,
        S_ROW,
        S_VERT,
        S_EDGE,
        S_TDIV,
        S_LMUL,
        S_LRES,
        S_MERGE,
        S_NDIV,
        S_NWAIT,
        S_SMUL,
        S_SRES,
        S_BOUND,
        S_EDONE,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic                         mode;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [WORD_W-1:0]     coef_value;
        logic signed [WORD_W-1:0]     pos_x;
        logic signed [WORD_W-1:0]     pos_y;
        logic signed [WORD_W-1:0]     pos_z;
        logic                         last_vertex;
    } in_item_t;

    typedef struct packed {
        logic [RECT_W-1:0] rect_left;
        logic [RECT_W-1:0] rect_top;
        logic [RECT_W-1:0] rect_width;
        logic [RECT_W-1:0] rect_height;
        logic              rect_empty;
    } result_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = WORD_MAX;
        end else if (v < SAT_LO) begin
            r = WORD_MIN;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/near_clip_screen_bounds.sv
//
// Screen bounding rectangle of a polygon clipped against the near plane.
// Requests enter through push/full; a request with mode 0 and an index below
// 24 loads one matrix coefficient (higher indices are ignored), a request with
// mode 1 delivers one polygon corner. The request with last_vertex set closes
// the polygon and produces one result, read through empty/pop. Registers
// z_near, view_width and view_height are set through cfg_write/cfg_index/
// cfg_data; the user must write them only while the block is idle, since the
// block itself does not enforce this. A two-entry input queue takes requests
// while the sequencer works. For a corner the sequencer runs the view
// transform, then each point merged into the bounds and each near-plane
// intersection, using the 33-step divider and the one shared multiplier. The
// closing corner adds the closing edge, and then the result is placed.
// The result waits in an output register until popped; while it waits, work
// continues until the next result is ready, which then holds until pop.
// Reset clears the coefficients and the polygon, drops any waiting result
// and loads the register defaults (z_near 6554, view 640 by 480).
//
`timescale 1ns / 1ps
`default_nettype none

module near_clip_screen_bounds (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  nccsb_pkg::in_item_t                item,
    output logic                               empty,
    input  logic                               pop,
    output nccsb_pkg::result_t                 result,
    input  logic                               cfg_write,
    input  logic [nccsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nccsb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nccsb_pkg::*;

    logic [ZN_W-1:0]  z_near_reg;
    logic [DIM_W-1:0] view_width_reg;
    logic [DIM_W-1:0] view_height_reg;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            z_near_reg      <= Z_NEAR_RESET;
            view_width_reg  <= WIDTH_RESET;
            view_height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            if (cfg_index == CFG_Z_NEAR) begin
                z_near_reg <= ZN_W'(cfg_data);
            end
            if (cfg_index == CFG_VIEW_WIDTH) begin
                view_width_reg <= DIM_W'(cfg_data);
            end
            if (cfg_index == CFG_VIEW_HEIGHT) begin
                view_height_reg <= DIM_W'(cfg_data);
            end
        end
    end

    nccsb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    nccsb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .z_near      (z_near_reg),
        .view_width  (view_width_reg),
        .view_height (view_height_reg),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/nccsb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nccsb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  nccsb_pkg::in_item_t item,
    output logic             cmd_valid,
    output nccsb_pkg::cmd_t  cmd,
    input  logic             cmd_pop
);
    import nccsb_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       classified;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        classified.item = item;
        if (item.mode) begin
            classified.kind = K_VERTEX;
        end else if (item.coef_index < COEF_IDX_W'(COEF_N)) begin
            classified.kind = K_COEF;
        end else begin
            classified.kind = K_IGNORE;
        end
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nccsb_div.sv
`timescale 1ns / 1ps
`default_nettype none

module nccsb_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [nccsb_pkg::DIV_NW-1:0]    num,
    input  logic [nccsb_pkg::DIV_DW-1:0]    den,
    output nccsb_pkg::div_status_t          status,
    output logic [nccsb_pkg::DIV_QW-1:0]    quot,
    output logic                            ovf
);
    import nccsb_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_DW-1:0]    den_reg;
    logic [DIV_QW-1:0]    low_reg;
    logic [DIV_QW-1:0]    q_reg;
    logic                 ovf_reg;
    logic [DIV_DW:0]      trial;
    logic                 fits;

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = q_reg;
    assign ovf         = ovf_reg;

    always_comb
    begin
        trial = {rem_reg, low_reg[DIV_QW-1]};
        fits  = (trial >= (DIV_DW+1)'(den_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
            low_reg <= num[DIV_QW-1:0];
            den_reg <= den;
            q_reg   <= '0;
            ovf_reg <= (DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den);
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DW'(trial - (DIV_DW+1)'(den_reg)) : trial[DIV_DW-1:0];
            low_reg <= {low_reg[DIV_QW-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_QW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nccsb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nccsb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  nccsb_pkg::cmd_t               cmd,
    output logic                          cmd_pop,
    input  logic [nccsb_pkg::ZN_W-1:0]    z_near,
    input  logic [nccsb_pkg::DIM_W-1:0]   view_width,
    input  logic [nccsb_pkg::DIM_W-1:0]   view_height,
    input  logic                          pop,
    output logic                          empty,
    output nccsb_pkg::result_t            result
);
    import nccsb_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] LERP_HALF  = PROD_W'(1) <<< (T_SHIFT - 1);
    localparam logic signed [MUL_W-1:0]  ONE        = MUL_W'(1) <<< FRAC_BITS;
    localparam logic signed [BND_W-1:0]  PAD_B      = BND_W'(PAD);
    localparam logic [COEF_IDX_W-1:0]    PROJ_BASE  = COEF_IDX_W'(12);

    state_t state_reg, state_next;

    logic signed [WORD_W-1:0] coef_reg [COEF_N];
    logic signed [WORD_W-1:0] coef_next [COEF_N];
    logic signed [WORD_W-1:0] dp_reg [3], dp_next [3];
    logic signed [WORD_W-1:0] res_reg [3], res_next [3];
    logic signed [WORD_W-1:0] prev_reg [3], prev_next [3];
    logic signed [WORD_W-1:0] first_reg [3], first_next [3];
    logic signed [WORD_W-1:0] ea_reg [3], ea_next [3];
    logic signed [WORD_W-1:0] eb_reg [3], eb_next [3];
    logic [1:0]               k_reg, k_next;
    logic [1:0]               j_reg, j_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     proj_reg, proj_next;
    logic                     last_reg, last_next;
    logic                     have_first_reg, have_first_next;
    logic                     edge_sel_reg, edge_sel_next;
    logic                     merge_b_reg, merge_b_next;
    logic                     sel_reg, sel_next;
    logic [WORD_W-1:0]        t_reg, t_next;
    logic signed [WORD_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [WORD_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [BND_W-1:0]  min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic signed [BND_W-1:0]  max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic                     bounds_valid_reg, bounds_valid_next;
    logic                     res_valid_reg, res_valid_next;
    result_t                  result_reg, result_next;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [COEF_IDX_W-1:0]    row_base, coef_sel;
    logic signed [PROD_W-1:0] term;
    logic signed [PROD_W-1:0] row_sum;
    logic signed [WORD_W:0]   zc;
    logic                     a_out, b_out;
    logic signed [WORD_W+1:0] n_diff, d_diff, n_abs, d_abs;
    logic signed [WORD_W:0]   ld, ld_abs;
    logic signed [WORD_W+1:0] off;
    logic signed [PROD_W-1:0] lval;
    logic signed [WORD_W-1:0] nv, nw;
    logic [WORD_W-1:0]        nv_abs, nw_abs;
    logic signed [WORD_W-1:0] ndc_val;
    logic                     ndc_neg;
    logic signed [BND_W-1:0]  sx_b, sy_b;
    logic signed [CMP_W-1:0]  r2, b2, bmin_x, bmin_y, bmax_x, bmax_y, left, top;
    logic signed [CMP_W-1:0]  right, bottom;
    logic                     fin_empty;
    result_t                  fin_result;
    logic                     res_load;

    logic                     div_start;
    logic [DIV_NW-1:0]        div_num;
    logic [DIV_DW-1:0]        div_den;
    div_status_t              div_st;
    logic [DIV_QW-1:0]        div_quot;
    logic                     div_ovf;

    nccsb_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_st),
        .quot   (div_quot),
        .ovf    (div_ovf)
    );

    assign empty  = !res_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        row_base = {1'b0, j_reg, 2'b00} + (proj_reg ? PROJ_BASE : COEF_IDX_W'(0));
        coef_sel = row_base + ((state_reg == S_ROW) ? COEF_IDX_W'(3) : COEF_IDX_W'(k_reg));
        term     = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
        row_sum  = PROD_W'(acc_reg) + PROD_W'(coef_reg[coef_sel]);

        zc     = -$signed({2'b00, z_near});
        a_out  = (ea_reg[2] > zc);
        b_out  = (eb_reg[2] > zc);
        n_diff = (WORD_W+2)'(zc) - (WORD_W+2)'(ea_reg[2]);
        d_diff = (WORD_W+2)'(eb_reg[2]) - (WORD_W+2)'(ea_reg[2]);
        n_abs  = n_diff[WORD_W+1] ? -n_diff : n_diff;
        d_abs  = d_diff[WORD_W+1] ? -d_diff : d_diff;

        ld     = (WORD_W+1)'(eb_reg[{1'b0, sel_reg}]) - (WORD_W+1)'(ea_reg[{1'b0, sel_reg}]);
        ld_abs = ld[WORD_W] ? -ld : ld;
        off    = (WORD_W+2)'((prod_reg + LERP_HALF) >>> T_SHIFT);
        lval   = ld[WORD_W] ? PROD_W'(ea_reg[{1'b0, sel_reg}]) - PROD_W'(off)
                            : PROD_W'(ea_reg[{1'b0, sel_reg}]) + PROD_W'(off);

        nv      = res_reg[{1'b0, sel_reg}];
        nw      = res_reg[2];
        nv_abs  = nv[WORD_W-1] ? WORD_W'(-nv) : WORD_W'(nv);
        nw_abs  = nw[WORD_W-1] ? WORD_W'(-nw) : WORD_W'(nw);
        ndc_neg = nv[WORD_W-1] ^ nw[WORD_W-1];
        if (ndc_neg) begin
            if (div_ovf || div_quot >= DIV_QW'(1) << (WORD_W - 1)) begin
                ndc_val = WORD_MIN;
            end else begin
                ndc_val = WORD_W'(-div_quot);
            end
        end else begin
            if (div_ovf || div_quot > DIV_QW'(WORD_MAX)) begin
                ndc_val = WORD_MAX;
            end else begin
                ndc_val = WORD_W'(div_quot);
            end
        end

        sx_b = BND_W'(sx_reg);
        sy_b = BND_W'(sy_reg);

        r2     = $signed(CMP_W'(view_width) << FRAC_BITS);
        b2     = $signed(CMP_W'(view_height) << FRAC_BITS);
        bmin_x = CMP_W'(min_x_reg);
        bmin_y = CMP_W'(min_y_reg);
        bmax_x = CMP_W'(max_x_reg);
        bmax_y = CMP_W'(max_y_reg);
        left   = (bmin_x > 0) ? bmin_x : '0;
        top    = (bmin_y > 0) ? bmin_y : '0;
        right  = (bmax_x < r2) ? bmax_x : r2;
        bottom = (bmax_y < b2) ? bmax_y : b2;
        fin_empty = !bounds_valid_reg || (view_width == '0) || (view_height == '0)
                    || (bmin_x >= r2) || (bmax_x <= 0) || (bmin_y >= b2) || (bmax_y <= 0);
        if (fin_empty) begin
            fin_result = '0;
            fin_result.rect_empty = 1'b1;
        end else begin
            fin_result.rect_left   = RECT_W'(left);
            fin_result.rect_top    = RECT_W'(top);
            fin_result.rect_width  = RECT_W'(right - left);
            fin_result.rect_height = RECT_W'(bottom - top);
            fin_result.rect_empty  = 1'b0;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        coef_next         = coef_reg;
        dp_next           = dp_reg;
        res_next          = res_reg;
        prev_next         = prev_reg;
        first_next        = first_reg;
        ea_next           = ea_reg;
        eb_next           = eb_reg;
        k_next            = k_reg;
        j_next            = j_reg;
        acc_next          = acc_reg;
        proj_next         = proj_reg;
        last_next         = last_reg;
        have_first_next   = have_first_reg;
        edge_sel_next     = edge_sel_reg;
        merge_b_next      = merge_b_reg;
        sel_next          = sel_reg;
        t_next            = t_reg;
        nx_next           = nx_reg;
        ny_next           = ny_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        min_x_next        = min_x_reg;
        min_y_next        = min_y_reg;
        max_x_next        = max_x_reg;
        max_y_next        = max_y_reg;
        bounds_valid_next = bounds_valid_reg;
        result_next       = result_reg;
        res_load          = 1'b0;
        cmd_pop           = 1'b0;
        mul_a             = MUL_W'(coef_reg[coef_sel]);
        mul_b             = MUL_W'(dp_reg[k_reg]);
        div_start         = 1'b0;
        div_num           = DIV_NW'(n_abs[WORD_W:0]) << T_SHIFT;
        div_den           = DIV_DW'(d_abs);

        unique case (state_reg)
            S_FETCH:
            begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        K_COEF:
                        begin
                            coef_next[cmd.item.coef_index] = cmd.item.coef_value;
                        end
                        K_VERTEX:
                        begin
                            dp_next[0] = cmd.item.pos_x;
                            dp_next[1] = cmd.item.pos_y;
                            dp_next[2] = cmd.item.pos_z;
                            last_next  = cmd.item.last_vertex;
                            proj_next  = 1'b0;
                            j_next     = '0;
                            k_next     = '0;
                            acc_next   = '0;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + ACC_W'(term);
                if (k_reg == 2'd2) begin
                    k_next     = '0;
                    state_next = S_ROW;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_ROW:
            begin
                res_next[j_reg] = sat_word(row_sum);
                acc_next        = '0;
                if (j_reg == 2'd2) begin
                    j_next     = '0;
                    sel_next   = 1'b0;
                    state_next = proj_reg ? S_NDIV : S_VERT;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_VERT:
            begin
                prev_next = res_reg;
                if (!have_first_reg) begin
                    first_next        = res_reg;
                    have_first_next   = 1'b1;
                    bounds_valid_next = 1'b0;
                    if (last_reg) begin
                        ea_next       = res_reg;
                        eb_next       = res_reg;
                        edge_sel_next = 1'b1;
                        state_next    = S_EDGE;
                    end else begin
                        state_next = S_FETCH;
                    end
                end else begin
                    ea_next       = prev_reg;
                    eb_next       = res_reg;
                    edge_sel_next = 1'b0;
                    state_next    = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (a_out && b_out) begin
                    state_next = S_EDONE;
                end else if (!a_out && !b_out) begin
                    dp_next      = eb_reg;
                    merge_b_next = 1'b1;
                    state_next   = S_MERGE;
                end else begin
                    div_start    = 1'b1;
                    merge_b_next = 1'b0;
                    state_next   = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (div_st.done) begin
                    t_next     = div_quot[WORD_W-1:0];
                    sel_next   = 1'b0;
                    state_next = S_LMUL;
                end
            end
            S_LMUL:
            begin
                mul_a      = MUL_W'(ld_abs);
                mul_b      = $signed({1'b0, t_reg});
                state_next = S_LRES;
            end
            S_LRES:
            begin
                dp_next[{1'b0, sel_reg}] = sat_word(lval);
                if (sel_reg) begin
                    dp_next[2] = WORD_W'(zc);
                    state_next = S_MERGE;
                end else begin
                    sel_next   = 1'b1;
                    state_next = S_LMUL;
                end
            end
            S_MERGE:
            begin
                proj_next  = 1'b1;
                j_next     = '0;
                k_next     = '0;
                acc_next   = '0;
                state_next = S_MUL;
            end
            S_NDIV:
            begin
                if (nw == '0) begin
                    if (sel_reg) begin
                        ny_next    = (nv > 0) ? WORD_MAX : ((nv < 0) ? WORD_MIN : '0);
                        sel_next   = 1'b0;
                        state_next = S_SMUL;
                    end else begin
                        nx_next    = (nv > 0) ? WORD_MAX : ((nv < 0) ? WORD_MIN : '0);
                        sel_next   = 1'b1;
                    end
                end else begin
                    div_start  = 1'b1;
                    div_num    = DIV_NW'(nv_abs) << FRAC_BITS;
                    div_den    = DIV_DW'(nw_abs);
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                if (div_st.done) begin
                    if (sel_reg) begin
                        ny_next    = ndc_val;
                        sel_next   = 1'b0;
                        state_next = S_SMUL;
                    end else begin
                        nx_next    = ndc_val;
                        sel_next   = 1'b1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_SMUL:
            begin
                if (sel_reg) begin
                    mul_a = $signed(MUL_W'(view_height));
                    mul_b = ONE - MUL_W'(ny_reg);
                end else begin
                    mul_a = $signed(MUL_W'(view_width));
                    mul_b = ONE + MUL_W'(nx_reg);
                end
                state_next = S_SRES;
            end
            S_SRES:
            begin
                if (sel_reg) begin
                    sy_next    = sat_word(prod_reg >>> 1);
                    state_next = S_BOUND;
                end else begin
                    sx_next    = sat_word(prod_reg >>> 1);
                    sel_next   = 1'b1;
                    state_next = S_SMUL;
                end
            end
            S_BOUND:
            begin
                if (!bounds_valid_reg) begin
                    min_x_next        = sx_b;
                    min_y_next        = sy_b;
                    max_x_next        = sx_b + PAD_B;
                    max_y_next        = sy_b + PAD_B;
                    bounds_valid_next = 1'b1;
                end else begin
                    if (sx_b < min_x_reg) begin
                        min_x_next = sx_b;
                    end
                    if (sy_b < min_y_reg) begin
                        min_y_next = sy_b;
                    end
                    if (sx_b + PAD_B > max_x_reg) begin
                        max_x_next = sx_b + PAD_B;
                    end
                    if (sy_b + PAD_B > max_y_reg) begin
                        max_y_next = sy_b + PAD_B;
                    end
                end
                if (!merge_b_reg && !b_out) begin
                    dp_next      = eb_reg;
                    merge_b_next = 1'b1;
                    state_next   = S_MERGE;
                end else begin
                    state_next = S_EDONE;
                end
            end
            S_EDONE:
            begin
                if (edge_sel_reg) begin
                    state_next = S_FINAL;
                end else if (last_reg) begin
                    ea_next       = prev_reg;
                    eb_next       = first_reg;
                    edge_sel_next = 1'b1;
                    state_next    = S_EDGE;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_FINAL:
            begin
                if (!res_valid_reg || pop) begin
                    res_load        = 1'b1;
                    result_next     = fin_result;
                    have_first_next = 1'b0;
                    state_next      = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase

        if (res_load) begin
            res_valid_next = 1'b1;
        end else if (pop) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_FETCH;
            have_first_reg   <= 1'b0;
            bounds_valid_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
            for (int i = 0; i < COEF_N; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg        <= state_next;
            have_first_reg   <= have_first_next;
            bounds_valid_reg <= bounds_valid_next;
            res_valid_reg    <= res_valid_next;
            coef_reg         <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        dp_reg       <= dp_next;
        res_reg      <= res_next;
        prev_reg     <= prev_next;
        first_reg    <= first_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        acc_reg      <= acc_next;
        proj_reg     <= proj_next;
        last_reg     <= last_next;
        edge_sel_reg <= edge_sel_next;
        merge_b_reg  <= merge_b_next;
        sel_reg      <= sel_next;
        t_reg        <= t_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        min_x_reg    <= min_x_next;
        min_y_reg    <= min_y_next;
        max_x_reg    <= max_x_next;
        max_y_reg    <= max_y_next;
        result_reg   <= result_next;
    end

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_final_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |-> (have_first_reg && edge_sel_reg))
        else $error("polygon closed without an open first vertex");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || pop))
        else $error("result overwritten before it was taken");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_reg.rect_empty) |->
        (result_reg.rect_width == '0 && result_reg.rect_height == '0))
        else $error("empty result with nonzero size");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nccsb_pkg::*;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int SETTLE_CYCLES = 2000;
    localparam longint ONE = 65536;

    class bounds_scoreboard;
        longint coefs[COEF_N];
        longint first_x, first_y, first_z;
        longint prev_x, prev_y, prev_z;
        bit have_first;
        longint min_x, min_y, max_x, max_y;
        bit box_valid;
        longint z_near, view_w, view_h;
        result_t rects[$];
        int errors;
        int rects_checked;
        int empty_rects;

        function new();
            foreach (coefs[i]) coefs[i] = 0;
            first_x = 0; first_y = 0; first_z = 0;
            prev_x = 0; prev_y = 0; prev_z = 0;
            have_first = 0;
            min_x = 0; min_y = 0; max_x = 0; max_y = 0;
            box_valid = 0;
            z_near = 6554; view_w = 640; view_h = 480;
            errors = 0; rects_checked = 0; empty_rects = 0;
        endfunction

        function void set_register(cfg_index_t idx, longint value);
            case (idx)
                CFG_Z_NEAR: z_near = value & 64'h7FFF_FFFF;
                CFG_VIEW_WIDTH: view_w = value & 64'hFFF;
                CFG_VIEW_HEIGHT: view_h = value & 64'hFFF;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint row_times(int base, longint x, longint y, longint z);
            longint acc;
            acc = (coefs[base] * x + 32768) >>> FRAC_BITS;
            acc += (coefs[base + 1] * y + 32768) >>> FRAC_BITS;
            acc += (coefs[base + 2] * z + 32768) >>> FRAC_BITS;
            return clamp32(acc + coefs[base + 3]);
        endfunction

        function longint cut_coord(longint a, longint b, longint unsigned t);
            longint d;
            longint unsigned mag;
            longint off;
            d = b - a;
            mag = (d < 0) ? -d : d;
            off = longint'((mag * t + (64'd1 << 30)) >> 31);
            return clamp32((d < 0) ? a - off : a + off);
        endfunction

        function longint persp_div(longint v, longint w);
            if (w == 0) return (v > 0) ? 64'sd2147483647 : ((v < 0) ? -64'sd2147483648 : 0);
            return clamp32((v * ONE) / w);
        endfunction

        function void grow_box(longint x, longint y, longint z);
            longint cx, cy, cw, nx, ny, sx, sy;
            cx = row_times(12, x, y, z);
            cy = row_times(16, x, y, z);
            cw = row_times(20, x, y, z);
            nx = persp_div(cx, cw);
            ny = persp_div(cy, cw);
            sx = clamp32((view_w * (ONE + nx)) >>> 1);
            sy = clamp32((view_h * (ONE - ny)) >>> 1);
            if (!box_valid) begin
                min_x = sx; min_y = sy;
                max_x = sx + PAD; max_y = sy + PAD;
                box_valid = 1;
                return;
            end
            if (sx < min_x) min_x = sx;
            if (sy < min_y) min_y = sy;
            if (sx + PAD > max_x) max_x = sx + PAD;
            if (sy + PAD > max_y) max_y = sy + PAD;
        endfunction

        function void clip_segment(longint ax, longint ay, longint az,
                                   longint bx, longint by, longint bz);
            longint zc, n, d;
            longint unsigned un, ud, t;
            bit a_out, b_out;
            zc = -z_near;
            a_out = az > zc;
            b_out = bz > zc;
            if (a_out && b_out) return;
            if (!a_out && !b_out) begin
                grow_box(bx, by, bz);
                return;
            end
            n = zc - az;
            d = bz - az;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            t = (un << 31) / ud;
            grow_box(cut_coord(ax, bx, t), cut_coord(ay, by, t), zc);
            if (!b_out) grow_box(bx, by, bz);
        endfunction

        function void note_request(in_item_t it);
            longint wx, wy, wz, vx, vy, vz, r2, b2, left, top;
            result_t r;
            if (!it.mode) begin
                if (it.coef_index < COEF_N) coefs[it.coef_index] = longint'($signed(it.coef_value));
                return;
            end
            wx = longint'($signed(it.pos_x));
            wy = longint'($signed(it.pos_y));
            wz = longint'($signed(it.pos_z));
            vx = row_times(0, wx, wy, wz);
            vy = row_times(4, wx, wy, wz);
            vz = row_times(8, wx, wy, wz);
            if (!have_first) begin
                first_x = vx; first_y = vy; first_z = vz;
                have_first = 1;
                box_valid = 0;
            end else begin
                clip_segment(prev_x, prev_y, prev_z, vx, vy, vz);
            end
            prev_x = vx; prev_y = vy; prev_z = vz;
            if (!it.last_vertex) return;
            clip_segment(vx, vy, vz, first_x, first_y, first_z);
            have_first = 0;
            r = '0;
            r.rect_empty = 1'b1;
            r2 = view_w * ONE;
            b2 = view_h * ONE;
            if (box_valid && r2 != 0 && b2 != 0 && min_x < r2 && max_x > 0
                && min_y < b2 && max_y > 0) begin
                left = (min_x > 0) ? min_x : 0;
                top = (min_y > 0) ? min_y : 0;
                r.rect_left = RECT_W'(left);
                r.rect_top = RECT_W'(top);
                r.rect_width = RECT_W'(((max_x < r2) ? max_x : r2) - left);
                r.rect_height = RECT_W'(((max_y < b2) ? max_y : b2) - top);
                r.rect_empty = 1'b0;
            end
            rects.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (rects.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = rects.pop_front();
            rects_checked++;
            if (want.rect_empty) empty_rects++;
            if (got.rect_empty !== want.rect_empty)
                report($sformatf("rect_empty %b, expected %b", got.rect_empty, want.rect_empty));
            if (got.rect_left !== want.rect_left)
                report($sformatf("rect_left %h, expected %h", got.rect_left, want.rect_left));
            if (got.rect_top !== want.rect_top)
                report($sformatf("rect_top %h, expected %h", got.rect_top, want.rect_top));
            if (got.rect_width !== want.rect_width)
                report($sformatf("rect_width %h, expected %h", got.rect_width, want.rect_width));
            if (got.rect_height !== want.rect_height)
                report($sformatf("rect_height %h, expected %h", got.rect_height, want.rect_height));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bounds_scoreboard sb = new();
    longint cycles = 0;
    bit idling = 1'b1;
    int requests_sent = 0;
    int settings_used = 0;

    near_clip_screen_bounds u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out with %0d results outstanding.", sb.rects.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        bit take;
        result_t seen;
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            take = pop && !empty;
            seen = result;
            @(posedge clk);
            if (take) sb.check_result(seen);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (idling && $urandom_range(0, 15) == 0)
            begin
                stall = $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    function automatic in_item_t noise_item();
        in_item_t it;
        it.mode = 1'($urandom_range(0, 1));
        it.coef_index = COEF_IDX_W'($urandom);
        it.coef_value = WORD_W'($urandom);
        it.pos_x = WORD_W'($urandom);
        it.pos_y = WORD_W'($urandom);
        it.pos_z = WORD_W'($urandom);
        it.last_vertex = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t coef_item(int idx, longint value);
        in_item_t it;
        it = noise_item();
        it.mode = 1'b0;
        it.coef_index = COEF_IDX_W'(idx);
        it.coef_value = WORD_W'(value);
        return it;
    endfunction

    function automatic in_item_t corner_item(longint x, longint y, longint z, bit last);
        in_item_t it;
        it = noise_item();
        it.mode = 1'b1;
        it.pos_x = WORD_W'(x);
        it.pos_y = WORD_W'(y);
        it.pos_z = WORD_W'(z);
        it.last_vertex = last;
        return it;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send(in_item_t it);
        bit ok;
        if (idling && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
        begin
            @(negedge clk);
            ok = !full;
            @(posedge clk);
        end
        while (!ok);
        sb.note_request(it);
        if (it.mode || it.coef_index < COEF_N) requests_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.rects.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, longint value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic set_view(longint zn, longint w, longint h);
        write_register(CFG_Z_NEAR, zn);
        write_register(CFG_VIEW_WIDTH, w);
        write_register(CFG_VIEW_HEIGHT, h);
        settings_used++;
    endtask

    task automatic load_matrix(bit scramble);
        longint f;
        f = scramble ? longint'($urandom_range(32768, 196608)) : ONE;
        for (int i = 0; i < 12; i++)
        begin
            if (i == 0 || i == 5 || i == 10)
                send(coef_item(i, ONE + (scramble ? jitter(16384) : 0)));
            else if (i == 3 || i == 7)
                send(coef_item(i, scramble ? jitter(262144) : 0));
            else if (i == 11)
                send(coef_item(i, scramble ? -longint'($urandom_range(0, 1048576)) : 0));
            else
                send(coef_item(i, scramble ? jitter(16384) : 0));
        end
        for (int i = 12; i < COEF_N; i++)
        begin
            if (i == 12 || i == 17) send(coef_item(i, f));
            else if (i == 22) send(coef_item(i, -ONE));
            else if ((i == 14 || i == 18) && scramble) send(coef_item(i, jitter(8192)));
            else send(coef_item(i, 0));
        end
    endtask

    task automatic random_polygon();
        int corners;
        bit wild;
        longint cz;
        corners = $urandom_range(1, 6);
        wild = ($urandom_range(0, 7) == 0);
        cz = -longint'($urandom_range(0, 4194304)) + 1048576;
        for (int i = 0; i < corners; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send(coef_item($urandom_range(0, COEF_N - 1), jitter(131072)));
            if (wild)
                send(corner_item(longint'($signed($urandom)), longint'($signed($urandom)),
                                 longint'($signed($urandom)), i == corners - 1));
            else
                send(corner_item(jitter(2097152), jitter(2097152), cz + jitter(2097152),
                                 i == corners - 1));
        end
    endtask

    task automatic random_phase(int count);
        int start;
        int pick;
        in_item_t it;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                load_matrix(1'b1);
            end
            else if (pick < 9)
            begin
                send(noise_item());
            end
            else if (pick < 11)
            begin
                it = coef_item($urandom_range(COEF_N, 31), longint'($signed($urandom)));
                send(it);
            end
            else
            begin
                random_polygon();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_matrix(1'b0);
        send(coef_item(24, 32'sh7FFF_FFFF));
        send(coef_item(31, -64'sd2147483648));
        send(corner_item(0, 0, -5 * ONE, 1'b1));
        send(corner_item(-ONE, -ONE, -2 * ONE, 1'b0));
        send(corner_item(ONE, -ONE, ONE, 1'b0));
        send(corner_item(0, ONE, -3 * ONE, 1'b1));
        send(corner_item(0, 0, 2 * ONE, 1'b0));
        send(corner_item(ONE, 0, 3 * ONE, 1'b1));
        send(corner_item(32'sh7FFF_FFFF, -64'sd2147483648, -64'sd2147483648, 1'b0));
        send(corner_item(-64'sd2147483648, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
        send(corner_item(0, 0, -ONE, 1'b0));
        send(coef_item(22, 0));
        send(corner_item(ONE, ONE, -ONE, 1'b1));
        send(coef_item(22, -ONE));
        send(corner_item(100 * ONE, 0, -ONE, 1'b1));
        settle();

        set_view(1, 1, 1);
        send(corner_item(0, 0, -ONE, 1'b0));
        send(corner_item(ONE / 4, ONE / 4, -ONE, 1'b1));
        random_phase(300);
        settle();

        set_view(32'h7FFF_FFFF, 4095, 4095);
        send(corner_item(0, 0, -64'sd2147483648, 1'b1));
        random_phase(300);
        settle();

        set_view($urandom_range(6554, 131072), $urandom_range(1, 4095), $urandom_range(1, 4095));
        random_phase(300);
        settle();

        idling = 1'b0;
        set_view(6554, 640, 480);
        random_phase(330);
        settle();

        $display("Covered %0d requests under %0d register settings.", requests_sent,
                 settings_used + 1);
        $display("Checked %0d rectangles, %0d of them empty.", sb.rects_checked,
                 sb.empty_rects);
        if (sb.errors == 0 && sb.rects.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
